@@ hw/rtl/sbalu_pkg.sv @@
// package for the sixteen bit alu with flags
// operation codes, port field widths and the control word that rides the pipeline
// no dependencies
package sbalu_pkg;

	localparam int SBALU_DATA_WIDTH = 16;
	localparam int KIND_W = 4;
	localparam int FLAG_W = 6;

	localparam logic [KIND_W-1:0] KIND_ADD = 4'd0;
	localparam logic [KIND_W-1:0] KIND_SUB = 4'd1;
	localparam logic [KIND_W-1:0] KIND_MUL = 4'd2;
	localparam logic [KIND_W-1:0] KIND_DIV = 4'd3;
	localparam logic [KIND_W-1:0] KIND_AND = 4'd4;
	localparam logic [KIND_W-1:0] KIND_OR  = 4'd5;
	localparam logic [KIND_W-1:0] KIND_XOR = 4'd6;
	localparam logic [KIND_W-1:0] KIND_NOT = 4'd7;
	localparam logic [KIND_W-1:0] KIND_SHL = 4'd8;
	localparam logic [KIND_W-1:0] KIND_SHR = 4'd9;

	typedef struct packed {
		logic valid;
		logic ok;
		logic is_div;
		logic neg_q;
		logic neg_r;
		logic dz;
		logic cf;
		logic vf;
	} alu_ctrl_t;

endpackage

@@ hw/rtl/sbalu_front.sv @@
// decode stage: computes every non-division result and the division magnitudes
// depends on sbalu_pkg
module sbalu_front import sbalu_pkg::*; #(
	parameter int DATA_WIDTH = SBALU_DATA_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [KIND_W-1:0]     kind,
	input  logic [DATA_WIDTH-1:0] operand_a,
	input  logic [DATA_WIDTH-1:0] operand_b,
	output logic [DATA_WIDTH-1:0] dq_s1,
	output logic [DATA_WIDTH-1:0] mb_s1,
	output logic [DATA_WIDTH-1:0] res_s1,
	output alu_ctrl_t             ctrl_s1
);

	localparam int HALF = DATA_WIDTH / 2;

	logic [DATA_WIDTH-1:0]        bb;
	logic [DATA_WIDTH:0]          sum;
	logic signed [HALF-1:0]       ha;
	logic signed [HALF-1:0]       hb;
	logic signed [DATA_WIDTH-1:0] prod;
	logic                         sa;
	logic                         sb;
	logic [DATA_WIDTH-1:0]        ma;
	logic [DATA_WIDTH-1:0]        mb;
	logic [DATA_WIDTH-1:0]        res_n;
	alu_ctrl_t                    ctrl_n;

	always_comb begin
		bb   = (kind == KIND_SUB) ? DATA_WIDTH'(~operand_b + 1'b1) : operand_b;
		sum  = {1'b0, operand_a} + {1'b0, bb};
		ha   = operand_a[HALF-1:0];
		hb   = operand_b[HALF-1:0];
		prod = DATA_WIDTH'(ha) * DATA_WIDTH'(hb);
		sa   = operand_a[DATA_WIDTH-1];
		sb   = operand_b[DATA_WIDTH-1];
		ma   = sa ? DATA_WIDTH'(~operand_a + 1'b1) : operand_a;
		mb   = sb ? DATA_WIDTH'(~operand_b + 1'b1) : operand_b;

		res_n  = '0;
		ctrl_n = '0;
		ctrl_n.valid = in_valid;
		ctrl_n.ok    = 1'b1;
		case (kind)
			KIND_ADD, KIND_SUB: begin
				res_n     = sum[DATA_WIDTH-1:0];
				ctrl_n.cf = sum[DATA_WIDTH];
				ctrl_n.vf = (operand_a[DATA_WIDTH-1] ^ sum[DATA_WIDTH-1])
					& (bb[DATA_WIDTH-1] ^ sum[DATA_WIDTH-1]);
			end
			KIND_MUL: res_n = prod;
			KIND_DIV: begin
				// operand a rides along for the divide by zero case
				res_n         = operand_a;
				ctrl_n.is_div = 1'b1;
				ctrl_n.neg_q  = sa ^ sb;
				ctrl_n.neg_r  = sa;
				ctrl_n.dz     = (operand_b == '0);
			end
			KIND_AND: res_n = operand_a & operand_b;
			KIND_OR:  res_n = operand_a | operand_b;
			KIND_XOR: res_n = operand_a ^ operand_b;
			KIND_NOT: res_n = ~operand_a;
			KIND_SHL: res_n = {operand_a[DATA_WIDTH-2:0], 1'b0};
			KIND_SHR: res_n = {1'b0, operand_a[DATA_WIDTH-1:1]};
			default:  ctrl_n.ok = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (en) begin
			ctrl_s1 <= ctrl_n;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dq_s1  <= ma;
			mb_s1  <= mb;
			res_s1 <= res_n;
		end
	end

endmodule

@@ hw/rtl/sbalu_cell.sv @@
// one restoring division step, one quotient bit per cell, registered
// depends on sbalu_pkg
module sbalu_cell import sbalu_pkg::*; #(
	parameter int DATA_WIDTH = SBALU_DATA_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic [DATA_WIDTH-1:0] rem_in,
	input  logic [DATA_WIDTH-1:0] dq_in,
	input  logic [DATA_WIDTH-1:0] mb_in,
	input  logic [DATA_WIDTH-1:0] res_in,
	input  alu_ctrl_t             ctrl_in,
	output logic [DATA_WIDTH-1:0] rem_q,
	output logic [DATA_WIDTH-1:0] dq_q,
	output logic [DATA_WIDTH-1:0] mb_q,
	output logic [DATA_WIDTH-1:0] res_q,
	output alu_ctrl_t             ctrl_q
);

	logic [DATA_WIDTH-1:0] shifted;
	logic [DATA_WIDTH:0]   diff;
	logic                  ge;

	// partial remainder stays below the divisor, so its top bit is always clear
	always_comb begin
		shifted = {rem_in[DATA_WIDTH-2:0], dq_in[DATA_WIDTH-1]};
		diff    = {1'b0, shifted} - {1'b0, mb_in};
		ge      = ~diff[DATA_WIDTH];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else if (en) begin
			ctrl_q <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= ge ? diff[DATA_WIDTH-1:0] : shifted;
			dq_q  <= {dq_in[DATA_WIDTH-2:0], ge};
			mb_q  <= mb_in;
			res_q <= res_in;
		end
	end

endmodule

@@ hw/rtl/sbalu_back.sv @@
// output stage: sign fixup of quotient and remainder, flags, output register
// depends on sbalu_pkg
module sbalu_back import sbalu_pkg::*; #(
	parameter int DATA_WIDTH = SBALU_DATA_WIDTH,
	parameter int TDATA_W    = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic [DATA_WIDTH-1:0] rem_in,
	input  logic [DATA_WIDTH-1:0] quo_in,
	input  logic [DATA_WIDTH-1:0] res_in,
	input  alu_ctrl_t             ctrl_in,
	output logic                  m_tvalid,
	output logic [TDATA_W-1:0]    m_tdata,
	output logic [FLAG_W-1:0]     m_tuser
);

	logic [DATA_WIDTH-1:0] res_f;
	logic [DATA_WIDTH-1:0] rem_f;
	logic                  zero_f;
	logic                  neg_f;

	always_comb begin
		res_f = res_in;
		rem_f = '0;
		if (ctrl_in.is_div) begin
			if (ctrl_in.dz) begin
				res_f = '1;
				rem_f = res_in;
			end else begin
				res_f = ctrl_in.neg_q ? DATA_WIDTH'(~quo_in + 1'b1) : quo_in;
				rem_f = ctrl_in.neg_r ? DATA_WIDTH'(~rem_in + 1'b1) : rem_in;
			end
		end
		zero_f = ctrl_in.ok & (res_f == '0);
		neg_f  = ctrl_in.ok & res_f[DATA_WIDTH-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= ctrl_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && ctrl_in.valid) begin
			m_tdata <= TDATA_W'({rem_f, res_f});
			m_tuser <= {ctrl_in.dz, ctrl_in.vf, ctrl_in.cf, neg_f, zero_f, ctrl_in.is_div};
		end
	end

endmodule

@@ hw/rtl/sixteen_bit_alu_with_flags.sv @@
// top level of the sixteen bit alu with flags
// decode stage, a row of division cells and the output stage
// depends on sbalu_pkg, sbalu_front, sbalu_cell, sbalu_back
//
// usage:
// input beats carry the operation code on s_tuser and both operands on s_tdata;
// output beats carry result and remainder on m_tdata and six flags on m_tuser.
// every operation goes through the same pipeline: one decode stage, one
// division cell per data bit, then one output register that holds the output beat.
// one beat is accepted per cycle while the receiver does not stall; the rate is
// set by the division cells, each producing one quotient bit and handing its
// partial remainder to the next.
// when the receiver stalls, the whole pipeline holds and s_tready drops in the
// same cycle; no beat is lost or repeated.
// reset clears every valid bit, so the pipeline starts empty and m_tvalid low.
// unused operation codes give an all-zero output beat.
module sixteen_bit_alu_with_flags import sbalu_pkg::*; #(
	parameter int DATA_WIDTH = SBALU_DATA_WIDTH,
	parameter int TDATA_W    = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,  // operand_a, operand_b, zero pad
	input  logic [KIND_W-1:0]  s_tuser,  // kind
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,  // result, remainder, zero pad
	output logic [FLAG_W-1:0]  m_tuser   // remainder_valid, result_zero, negative_flag,
	                                     // carry_flag, signed_overflow, div_by_zero
);

	logic en;

	logic [DATA_WIDTH-1:0] rem_w  [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] dq_w   [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] mb_w   [DATA_WIDTH+1];
	logic [DATA_WIDTH-1:0] res_w  [DATA_WIDTH+1];
	alu_ctrl_t             ctrl_w [DATA_WIDTH+1];

	assign en       = ~m_tvalid | m_tready;
	assign s_tready = en;
	assign rem_w[0] = '0;

	sbalu_front #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.kind      (s_tuser),
		.operand_a (s_tdata[DATA_WIDTH-1:0]),
		.operand_b (s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
		.dq_s1     (dq_w[0]),
		.mb_s1     (mb_w[0]),
		.res_s1    (res_w[0]),
		.ctrl_s1   (ctrl_w[0])
	);

	for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
		sbalu_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.rem_in  (rem_w[i]),
			.dq_in   (dq_w[i]),
			.mb_in   (mb_w[i]),
			.res_in  (res_w[i]),
			.ctrl_in (ctrl_w[i]),
			.rem_q   (rem_w[i+1]),
			.dq_q    (dq_w[i+1]),
			.mb_q    (mb_w[i+1]),
			.res_q   (res_w[i+1]),
			.ctrl_q  (ctrl_w[i+1])
		);
	end

	sbalu_back #(
		.DATA_WIDTH(DATA_WIDTH),
		.TDATA_W   (TDATA_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.rem_in   (rem_w[DATA_WIDTH]),
		.quo_in   (dq_w[DATA_WIDTH]),
		.res_in   (res_w[DATA_WIDTH]),
		.ctrl_in  (ctrl_w[DATA_WIDTH]),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

@@ hw/rtl/sbalu_checker.sv @@
// port checker for the sixteen bit alu with flags, bound to the top level
// depends on sbalu_pkg and sixteen_bit_alu_with_flags
module sbalu_checker import sbalu_pkg::*; #(
	parameter int DATA_WIDTH = SBALU_DATA_WIDTH,
	parameter int TDATA_W    = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
	input logic               clk,
	input logic               arst_n,
	input logic               s_tready,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TDATA_W-1:0] m_tdata,
	input logic [FLAG_W-1:0]  m_tuser
);

	// stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output beat changed while stalled");

	// input side moves only when the output side can
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("s_tready out of step with output stall");

	// zero flag agrees with result
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata[DATA_WIDTH-1:0] == '0)
		else $error("zero flag with nonzero result");

	// divide by zero gives all ones and a valid remainder
	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[5] |-> m_tuser[0] && (&m_tdata[DATA_WIDTH-1:0]))
		else $error("divide by zero beat malformed");

endmodule

bind sixteen_bit_alu_with_flags sbalu_checker #(
	.DATA_WIDTH(DATA_WIDTH),
	.TDATA_W   (TDATA_W)
) u_sbalu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

@@ tb/sv/tb_sixteen_bit_alu_with_flags.sv @@
// self-checking testbench for sixteen_bit_alu_with_flags: a directed table, then random
// operations under three idling mixes, each beat checked against a typed row or a local predictor
// depends on sbalu_pkg and the rtl of sixteen_bit_alu_with_flags
module tb_sixteen_bit_alu_with_flags;
	timeunit 1ns;
	timeprecision 1ps;

	import sbalu_pkg::*;

	localparam int TB_TDATA_W = ((2 * SBALU_DATA_WIDTH + 7) / 8) * 8;
	localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 4'd10;
	localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 4'd15;
	localparam int RANDOM_PER_PHASE = 650;

	// same bit order as {m_tdata, m_tuser}
	typedef struct packed {
		logic [15:0] rem;
		logic [15:0] result;
		logic        dz;
		logic        vf;
		logic        cf;
		logic        nf;
		logic        zf;
		logic        rv;
	} alu_beat_t;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [15:0]       a;
		logic [15:0]       b;
		logic              typed;
		alu_beat_t         beat;
	} op_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [TB_TDATA_W-1:0] s_tdata = '0;   // operand_a, operand_b
	logic [KIND_W-1:0]     s_tuser = '0;   // kind
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [TB_TDATA_W-1:0] m_tdata;        // result, remainder
	logic [FLAG_W-1:0]     m_tuser;        // remainder_valid, zero, negative, carry, overflow, div_by_zero

	alu_beat_t expected_beats[$];
	op_row_t   op_table[$];
	int        err_count = 0;
	int        tx_idle_pct = 0;
	int        rx_idle_pct = 0;

	sixteen_bit_alu_with_flags DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic alu_beat_t predict_alu(input logic [KIND_W-1:0] k, input logic [15:0] a,
			input logic [15:0] b);
		alu_beat_t         r;
		logic [15:0]       bb;
		logic [16:0]       sum;
		logic [16:0]       ma;
		logic [16:0]       mb;
		logic [16:0]       qm;
		logic [16:0]       rm;
		logic signed [15:0] prod;
		logic              known;
		r = '0;
		known = 1'b1;
		case (k)
			KIND_ADD, KIND_SUB: begin
				bb = (k == KIND_SUB) ? (~b + 16'd1) : b;
				sum = {1'b0, a} + {1'b0, bb};
				r.result = sum[15:0];
				r.cf = sum[16];
				r.vf = (a[15] ^ sum[15]) & (bb[15] ^ sum[15]);
			end
			KIND_MUL: begin
				prod = $signed(a[7:0]) * $signed(b[7:0]);
				r.result = prod;
			end
			KIND_DIV: begin
				r.rv = 1'b1;
				if (b == 16'd0) begin
					r.result = 16'hFFFF;
					r.rem = a;
					r.dz = 1'b1;
				end else begin
					ma = a[15] ? (17'h10000 - {1'b0, a}) : {1'b0, a};
					mb = b[15] ? (17'h10000 - {1'b0, b}) : {1'b0, b};
					qm = ma / mb;
					rm = ma % mb;
					r.result = (a[15] ^ b[15]) ? (~qm[15:0] + 16'd1) : qm[15:0];
					r.rem = a[15] ? (~rm[15:0] + 16'd1) : rm[15:0];
				end
			end
			KIND_AND: r.result = a & b;
			KIND_OR:  r.result = a | b;
			KIND_XOR: r.result = a ^ b;
			KIND_NOT: r.result = ~a;
			KIND_SHL: r.result = {a[14:0], 1'b0};
			KIND_SHR: r.result = {1'b0, a[15:1]};
			default:  known = 1'b0;
		endcase
		r.zf = known && (r.result == 16'd0);
		r.nf = known && r.result[15];
		return r;
	endfunction

	function automatic logic [15:0] rand_word();
		case ($urandom_range(0, 11))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'h8000;
			3:       return 16'h7FFF;
			4:       return 16'h0001;
			5:       return 16'h0080;
			6:       return 16'h007F;
			7:       return 16'($urandom_range(0, 15));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic add_row(input logic [KIND_W-1:0] k, input logic [15:0] a, input logic [15:0] b,
			input logic typed, input alu_beat_t beat);
		op_row_t row;
		row.kind = k;
		row.a = a;
		row.b = b;
		row.typed = typed;
		row.beat = beat;
		op_table.push_back(row);
	endtask

	task automatic send_op(input logic [KIND_W-1:0] k, input logic [15:0] a, input logic [15:0] b,
			input logic typed, input alu_beat_t beat);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= k;
		s_tdata <= {b, a};
		do @(posedge clk); while (s_tready !== 1'b1);
		expected_beats.push_back(typed ? beat : predict_alu(k, a, b));
	endtask

	task automatic cmp_field(input string name, input logic [15:0] exp_v, input logic [15:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected %h, got %h", name, exp_v, got_v);
			err_count++;
		end
	endtask

	task automatic check_beat(input alu_beat_t got);
		alu_beat_t exp_b;
		if (expected_beats.size() == 0) begin
			$error("output beat with nothing expected: %h", got);
			err_count++;
		end else begin
			exp_b = expected_beats.pop_front();
			cmp_field("result", exp_b.result, got.result);
			cmp_field("remainder", exp_b.rem, got.rem);
			cmp_field("remainder_valid", exp_b.rv, got.rv);
			cmp_field("result_zero", exp_b.zf, got.zf);
			cmp_field("negative_flag", exp_b.nf, got.nf);
			cmp_field("carry_flag", exp_b.cf, got.cf);
			cmp_field("signed_overflow", exp_b.vf, got.vf);
			cmp_field("div_by_zero", exp_b.dz, got.dz);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready)
			check_beat({m_tdata[31:0], m_tuser});
		m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	initial begin
		logic [KIND_W-1:0] k;
		logic [15:0]       a;
		logic [15:0]       b;

		// typed beats are {remainder, result, dz vf cf nf zf rv}
		add_row(KIND_ADD, 16'h0000, 16'h0000, 1'b0, '0);
		add_row(KIND_ADD, 16'hFFFF, 16'h0001, 1'b1, {16'h0000, 16'h0000, 6'b001010});
		add_row(KIND_ADD, 16'h7FFF, 16'h0001, 1'b1, {16'h0000, 16'h8000, 6'b010100});
		add_row(KIND_ADD, 16'hFFFF, 16'hFFFF, 1'b0, '0);
		add_row(KIND_SUB, 16'h8000, 16'h0001, 1'b0, '0);
		add_row(KIND_SUB, 16'h0000, 16'h0001, 1'b0, '0);
		add_row(KIND_SUB, 16'h1234, 16'h1234, 1'b0, '0);
		add_row(KIND_MUL, 16'h007F, 16'h007F, 1'b0, '0);
		add_row(KIND_MUL, 16'h0080, 16'h0080, 1'b0, '0);
		add_row(KIND_MUL, 16'hFF80, 16'hA5FF, 1'b0, '0);
		add_row(KIND_DIV, 16'h1234, 16'h0000, 1'b1, {16'h1234, 16'hFFFF, 6'b100101});
		add_row(KIND_DIV, 16'h8000, 16'hFFFF, 1'b1, {16'h0000, 16'h8000, 6'b000101});
		add_row(KIND_DIV, 16'h0000, 16'h0000, 1'b1, {16'h0000, 16'hFFFF, 6'b100101});
		add_row(KIND_DIV, 16'hFFF9, 16'h0002, 1'b0, '0);
		add_row(KIND_DIV, 16'h0007, 16'hFFFE, 1'b0, '0);
		add_row(KIND_DIV, 16'h7FFF, 16'h8000, 1'b0, '0);
		add_row(KIND_AND, 16'hFFFF, 16'h0000, 1'b0, '0);
		add_row(KIND_OR,  16'h0000, 16'h0000, 1'b1, {16'h0000, 16'h0000, 6'b000010});
		add_row(KIND_XOR, 16'hAAAA, 16'h5555, 1'b0, '0);
		add_row(KIND_NOT, 16'h0000, 16'hFFFF, 1'b0, '0);
		add_row(KIND_SHL, 16'h8001, 16'hFFFF, 1'b0, '0);
		add_row(KIND_SHR, 16'hFFFF, 16'h0000, 1'b0, '0);
		add_row(KIND_UNUSED_LO, 16'hFFFF, 16'hFFFF, 1'b1, '0);
		add_row(KIND_UNUSED_HI, 16'h0000, 16'h0000, 1'b1, '0);

		tx_idle_pct = 15;
		rx_idle_pct = 66;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (op_table[i])
			send_op(op_table[i].kind, op_table[i].a, op_table[i].b, op_table[i].typed,
				op_table[i].beat);

		for (int ph = 0; ph < 3; ph++) begin
			tx_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 66 : 0;
			rx_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 15 : 0;
			repeat (RANDOM_PER_PHASE) begin
				if ($urandom_range(0, 9) == 0)
					k = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
				else
					k = KIND_W'($urandom_range(KIND_ADD, KIND_SHR));
				a = rand_word();
				b = rand_word();
				if (k == KIND_DIV && $urandom_range(0, 5) == 0)
					b = 16'h0000;
				send_op(k, a, b, 1'b0, '0);
			end
		end
		s_tvalid <= 1'b0;

		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
